[hdl/stl_pkg.sv]
// Shared types, constants and the half-precision conversion for the terrain height lookup.
package stl_pkg;

    localparam int ONE_Q       = 16384;
    localparam int CELL_COUNT  = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;
    localparam int DIV_STAGES  = 4;
    localparam int DIV_BITS    = 4;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    localparam logic [1:0] CURVE_CONT = 2'd0;
    localparam logic [1:0] CURVE_EROS = 2'd1;
    localparam logic [1:0] CURVE_PEAK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_C = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_E = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_P = 2'd3;

    typedef struct packed {
        logic               kind;
        logic [1:0]         curve_sel;
        logic [2:0]         point_slot;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic [4:0]         cell_c;
        logic [4:0]         cell_e;
        logic [4:0]         cell_p;
    } stl_in_t;

    typedef struct packed {
        logic [13:0] height_half;
        logic        refused;
    } stl_out_t;

    typedef struct packed {
        logic vld;
        logic is_eval;
        logic refused;
    } stl_tag_t;

    typedef struct packed {
        stl_tag_t           tag;
        logic               ld_en;
        logic [2:0]         ld_slot;
        logic signed [15:0] ld_x;
        logic signed [15:0] ld_y;
        logic signed [15:0] x;
        logic [3:0]         n;
        logic               lo;
        logic               hi;
        logic               found;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] sx0;
        logic signed [15:0] sy0;
        logic signed [15:0] sx1;
        logic signed [15:0] sy1;
        logic signed [15:0] yfirst;
        logic signed [15:0] ylast;
    } stl_scan_t;

    // Value in [0, 16384] as Q1.14, converted to half bits with ties to even.
    function automatic logic [13:0] q14_to_half(input logic [14:0] v);
        logic [3:0]  p;
        logic [3:0]  s;
        logic [14:0] sh;
        logic [14:0] m;
        logic [14:0] rem;
        logic [14:0] mid;
        logic [15:0] h;
        p = '0;
        for (int k = 1; k < 15; k++)
        begin
            if (v[k])
                p = 4'(k);
        end
        s   = p - 4'd10;
        sh  = v << (4'd10 - p);
        m   = v >> s;
        rem = v & ((15'd1 << s) - 15'd1);
        mid = 15'd1 << (s - 4'd1);
        if (v == '0)
            h = '0;
        else if (p <= 4'd10)
            h = ((16'(p) + 16'd1) << 10) + 16'(sh[9:0]);
        else
        begin
            h = ((16'(p) + 16'd1) << 10) + 16'(m[9:0]);
            if (rem > mid || (rem == mid && m[0]))
                h = h + 16'd1;
        end
        return h[13:0];
    endfunction

endpackage

[hdl/stl_scan.sv]
// Breakpoint store and segment search for one curve, one slot per pipeline stage.
module stl_scan #(
    parameter int MAX_POINTS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  stl_pkg::stl_tag_t   tag,
    input  logic                ld_en,
    input  logic [2:0]          ld_slot,
    input  logic signed [15:0]  ld_x,
    input  logic signed [15:0]  ld_y,
    input  logic signed [15:0]  coord,
    input  logic [3:0]          npts,
    output stl_pkg::stl_scan_t  res
);

    stl_pkg::stl_scan_t st_reg  [MAX_POINTS+1];
    stl_pkg::stl_scan_t st_next [MAX_POINTS+1];

    logic signed [15:0] x_tab_reg [MAX_POINTS];
    logic signed [15:0] y_tab_reg [MAX_POINTS];

    always_comb
    begin
        st_next[0]         = '0;
        st_next[0].tag     = tag;
        st_next[0].ld_en   = ld_en;
        st_next[0].ld_slot = ld_slot;
        st_next[0].ld_x    = ld_x;
        st_next[0].ld_y    = ld_y;
        st_next[0].x       = coord;
        st_next[0].n       = npts;
    end

    // A load writes its slot when it passes that slot's stage, so items ahead of it
    // still see the old breakpoint and items behind it see the new one.
    for (genvar k = 0; k < MAX_POINTS; k++)
    begin : g_stage
        stl_pkg::stl_scan_t s;

        always_comb
        begin
            s = st_reg[k];
            if (k == 0)
            begin
                s.yfirst = y_tab_reg[k];
                s.lo     = (s.x <= x_tab_reg[k]);
            end
            else if (32'(s.n) > k && !s.found && s.x < x_tab_reg[k])
            begin
                s.found = 1'b1;
                s.sx0   = s.px;
                s.sy0   = s.py;
                s.sx1   = x_tab_reg[k];
                s.sy1   = y_tab_reg[k];
            end
            if (32'(s.n) == k + 1)
            begin
                s.ylast = y_tab_reg[k];
                s.hi    = (s.x >= x_tab_reg[k]);
            end
            s.px = x_tab_reg[k];
            s.py = y_tab_reg[k];
        end

        assign st_next[k+1] = s;

        always_ff @(posedge clk)
        begin
            if (adv && st_reg[k].tag.vld && st_reg[k].ld_en && 32'(st_reg[k].ld_slot) == k)
            begin
                x_tab_reg[k] <= st_reg[k].ld_x;
                y_tab_reg[k] <= st_reg[k].ld_y;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= MAX_POINTS; k++)
                st_reg[k] <= '0;
        end
        else if (adv)
        begin
            st_reg <= st_next;
        end
    end

    assign res = st_reg[MAX_POINTS];

endmodule

[hdl/stl_interp.sv]
// Curve value from the search result: product, pipelined divide and rounding.
module stl_interp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  stl_pkg::stl_scan_t res,
    output stl_pkg::stl_tag_t  tag,
    output logic signed [15:0] val
);

    localparam int NST = stl_pkg::DIV_STAGES + 2;

    typedef struct packed {
        stl_pkg::stl_tag_t  tag;
        logic               use_i;
        logic signed [15:0] cval;
        logic signed [15:0] y0;
        logic               neg;
        logic [15:0]        a;
        logic [15:0]        b;
        logic [15:0]        d;
        logic [15:0]        rem;
        logic [15:0]        pl;
        logic [15:0]        q;
    } stl_ip_t;

    stl_ip_t ip_reg  [NST];
    stl_ip_t ip_next [NST];

    stl_pkg::stl_tag_t  tag_reg, tag_next;
    logic signed [15:0] val_reg, val_next;

    logic signed [16:0] dx17, ax17, dy17, by17;
    logic [31:0]        prod;

    always_comb
    begin
        dx17 = {res.sx1[15], res.sx1} - {res.sx0[15], res.sx0};
        ax17 = {res.x[15], res.x} - {res.sx0[15], res.sx0};
        dy17 = {res.sy1[15], res.sy1} - {res.sy0[15], res.sy0};
        by17 = dy17[16] ? -dy17 : dy17;

        ip_next[0]       = '0;
        ip_next[0].tag   = res.tag;
        ip_next[0].use_i = (res.n >= 4'd2) && !res.lo && !res.hi && res.found;
        if (res.n == 4'd0)
            ip_next[0].cval = '0;
        else if (res.n == 4'd1 || res.lo)
            ip_next[0].cval = res.yfirst;
        else
            ip_next[0].cval = res.ylast;
        ip_next[0].y0  = res.sy0;
        ip_next[0].neg = dy17[16];
        ip_next[0].a   = ax17[15:0];
        ip_next[0].b   = by17[15:0];
        ip_next[0].d   = dx17[15:0];

        prod           = ip_reg[0].a * ip_reg[0].b;
        ip_next[1]     = ip_reg[0];
        ip_next[1].rem = prod[31:16];
        ip_next[1].pl  = prod[15:0];
        ip_next[1].q   = '0;
    end

    // Restoring division; the product is below d * 2^16, so the quotient has 16 bits.
    for (genvar g = 0; g < stl_pkg::DIV_STAGES; g++)
    begin : g_div
        stl_ip_t     s;
        logic [16:0] t;

        always_comb
        begin
            s = ip_reg[g+1];
            t = '0;
            for (int j = 0; j < stl_pkg::DIV_BITS; j++)
            begin
                t = {s.rem, s.pl[15]};
                s.pl = s.pl << 1;
                if (t >= {1'b0, s.d})
                begin
                    s.rem = 16'(t - {1'b0, s.d});
                    s.q   = {s.q[14:0], 1'b1};
                end
                else
                begin
                    s.rem = t[15:0];
                    s.q   = {s.q[14:0], 1'b0};
                end
            end
        end

        assign ip_next[g+2] = s;
    end

    logic        rnd;
    logic [16:0] mag;
    logic [17:0] sum;

    always_comb
    begin
        if (ip_reg[NST-1].neg)
            rnd = ({ip_reg[NST-1].rem, 1'b0} > {1'b0, ip_reg[NST-1].d});
        else
            rnd = ({ip_reg[NST-1].rem, 1'b0} >= {1'b0, ip_reg[NST-1].d});
        mag = {1'b0, ip_reg[NST-1].q} + 17'(rnd);
        if (ip_reg[NST-1].neg)
            sum = {{2{ip_reg[NST-1].y0[15]}}, ip_reg[NST-1].y0} - {1'b0, mag};
        else
            sum = {{2{ip_reg[NST-1].y0[15]}}, ip_reg[NST-1].y0} + {1'b0, mag};
        tag_next = ip_reg[NST-1].tag;
        val_next = ip_reg[NST-1].use_i ? $signed(sum[15:0]) : ip_reg[NST-1].cval;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
                ip_reg[k] <= '0;
            tag_reg <= '0;
            val_reg <= '0;
        end
        else if (adv)
        begin
            for (int k = 0; k < NST; k++)
                ip_reg[k] <= ip_next[k];
            tag_reg <= tag_next;
            val_reg <= val_next;
        end
    end

    assign tag = tag_reg;
    assign val = val_reg;

endmodule

[hdl/stl_blend.sv]
// Blend of the three curve values, clamp to [0,1] and conversion to half bits.
module stl_blend (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  stl_pkg::stl_tag_t  tag,
    input  logic signed [15:0] cv,
    input  logic signed [15:0] ev,
    input  logic signed [15:0] pv,
    output stl_pkg::stl_tag_t  tag_out,
    output stl_pkg::stl_out_t  res
);

    localparam logic signed [37:0] BIAS  = 38'sd81920;
    localparam logic signed [37:0] LIMIT = 38'sd81925;

    stl_pkg::stl_tag_t t0_reg, t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;

    logic signed [18:0] a_reg, a_next, a1_reg;
    logic signed [17:0] u_reg, u_next, w_reg, w_next;
    logic signed [35:0] pr_reg, pr_next;
    logic [16:0]        xs_reg, xs_next, xs3_reg;
    logic               xneg_reg, xneg_next, big_reg, big_next;
    logic               xneg3_reg, big3_reg;
    logic [14:0]        q0_reg, q0_next;
    logic [14:0]        h_reg, h_next;
    stl_pkg::stl_out_t  out_reg, out_next;

    logic signed [36:0] m;
    logic signed [37:0] m2;
    logic signed [37:0] xq;
    logic [30:0]        qm;
    logic [17:0]        r;
    logic [14:0]        hq;

    always_comb
    begin
        a_next = $signed({{3{cv[15]}}, cv}) + $signed({{2{cv[15]}}, cv, 1'b0}) + 19'sd16384;
        u_next = $signed({pv[15], pv, 1'b0}) - 18'sd16384;
        w_next = 18'sd16384 - $signed({{2{ev[15]}}, ev});

        pr_next = u_reg * w_reg;

        // height = floor(floor((2M + 5S) / 2^15) / 5) with M = S*(3c+S) + (2p-S)*(S-e).
        m         = $signed({{4{a1_reg[18]}}, a1_reg, 14'b0}) + $signed({pr_reg[35], pr_reg});
        m2        = $signed({m, 1'b0}) + BIAS;
        xq        = m2 >>> 15;
        xneg_next = xq[37];
        big_next  = !xq[37] && (xq >= LIMIT);
        xs_next   = xq[16:0];

        qm      = 31'(xs_reg) * 31'd13107;
        q0_next = qm[30:16];

        r  = 18'(xs3_reg) - 18'(q0_reg) * 18'd5;
        hq = q0_reg + 15'(r >= 18'd5);
        if (xneg3_reg)
            h_next = '0;
        else if (big3_reg)
            h_next = 15'(stl_pkg::ONE_Q);
        else
            h_next = hq;

        out_next.refused     = t4_reg.refused;
        out_next.height_half = t4_reg.refused ? 14'd0 : stl_pkg::q14_to_half(h_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_reg    <= '0;
            t1_reg    <= '0;
            t2_reg    <= '0;
            t3_reg    <= '0;
            t4_reg    <= '0;
            t5_reg    <= '0;
            a_reg     <= '0;
            a1_reg    <= '0;
            u_reg     <= '0;
            w_reg     <= '0;
            pr_reg    <= '0;
            xs_reg    <= '0;
            xs3_reg   <= '0;
            xneg_reg  <= 1'b0;
            big_reg   <= 1'b0;
            xneg3_reg <= 1'b0;
            big3_reg  <= 1'b0;
            q0_reg    <= '0;
            h_reg     <= '0;
            out_reg   <= '0;
        end
        else if (adv)
        begin
            t0_reg    <= tag;
            a_reg     <= a_next;
            u_reg     <= u_next;
            w_reg     <= w_next;
            t1_reg    <= t0_reg;
            a1_reg    <= a_reg;
            pr_reg    <= pr_next;
            t2_reg    <= t1_reg;
            xs_reg    <= xs_next;
            xneg_reg  <= xneg_next;
            big_reg   <= big_next;
            t3_reg    <= t2_reg;
            q0_reg    <= q0_next;
            xs3_reg   <= xs_reg;
            xneg3_reg <= xneg_reg;
            big3_reg  <= big_reg;
            t4_reg    <= t3_reg;
            h_reg     <= h_next;
            t5_reg    <= t4_reg;
            out_reg   <= out_next;
        end
    end

    assign tag_out = t5_reg;
    assign res     = out_reg;

endmodule

[hdl/spline_terrain_height_lut.sv]
// Terrain height lookup: three piecewise-linear curves blended into one half-precision height.
// An item enters in every cycle in which the output is free or being taken. The pipeline depth
// is set by the segment search, which spends one stage per breakpoint slot, followed by a
// four-stage divider and the blend.
// Load items travel the same pipeline, write their slot as they pass it and give no result.
// A stall at the output holds every stage at once, so in_ready follows out_ready whenever a
// result is waiting.
module spline_terrain_height_lut #(
    parameter int MAX_POINTS = 8,
    parameter int LUT_SIZE   = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  stl_pkg::stl_in_t                      in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output stl_pkg::stl_out_t                     out_data,
    input  logic                                  cfg_we,
    input  logic [stl_pkg::CFG_IDX_W-1:0]         cfg_idx,
    input  logic [stl_pkg::CFG_DATA_W-1:0]        cfg_data
);

    logic       enable_reg;
    logic [3:0] count_c_reg, count_e_reg, count_p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b1;
            count_c_reg <= '0;
            count_e_reg <= '0;
            count_p_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                stl_pkg::REG_ENABLE:  enable_reg  <= cfg_data[0];
                stl_pkg::REG_COUNT_C: count_c_reg <= cfg_data;
                stl_pkg::REG_COUNT_E: count_e_reg <= cfg_data;
                stl_pkg::REG_COUNT_P: count_p_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Lattice coordinates, worked out at elaboration; indices past the lattice saturate.
    logic signed [15:0] coord_lut [stl_pkg::CELL_COUNT];

    for (genvar i = 0; i < stl_pkg::CELL_COUNT; i++)
    begin : g_coord
        localparam int TOP = LUT_SIZE - 1;
        localparam int IDX = (i > TOP) ? TOP : i;
        localparam int Q   = (IDX * 32768 + TOP / 2) / TOP - stl_pkg::ONE_Q;
        assign coord_lut[i] = 16'(Q);
    end

    function automatic logic [3:0] eff_count(input logic [3:0] cnt);
        return (32'(cnt) > MAX_POINTS) ? 4'(MAX_POINTS) : cnt;
    endfunction

    logic              adv, accept, is_load;
    stl_pkg::stl_tag_t in_tag;
    stl_pkg::stl_tag_t blend_tag;

    assign adv       = !out_valid || out_ready;
    assign in_ready  = adv;
    assign accept    = in_valid && in_ready;
    assign is_load   = (in_data.kind == stl_pkg::KIND_LOAD);
    assign out_valid = blend_tag.vld && blend_tag.is_eval;

    always_comb
    begin
        in_tag.vld     = accept;
        in_tag.is_eval = (in_data.kind == stl_pkg::KIND_EVAL);
        in_tag.refused = (in_data.kind == stl_pkg::KIND_EVAL) && !enable_reg;
    end

    stl_pkg::stl_scan_t sc_c, sc_e, sc_p;
    stl_pkg::stl_tag_t  it_c;
    logic signed [15:0] v_c, v_e, v_p;

    stl_scan #(.MAX_POINTS(MAX_POINTS)) u_scan_c (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .tag     (in_tag),
        .ld_en   (is_load && in_data.curve_sel == stl_pkg::CURVE_CONT),
        .ld_slot (in_data.point_slot),
        .ld_x    (in_data.point_x),
        .ld_y    (in_data.point_y),
        .coord   (coord_lut[in_data.cell_c]),
        .npts    (eff_count(count_c_reg)),
        .res     (sc_c)
    );

    stl_scan #(.MAX_POINTS(MAX_POINTS)) u_scan_e (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .tag     (in_tag),
        .ld_en   (is_load && in_data.curve_sel == stl_pkg::CURVE_EROS),
        .ld_slot (in_data.point_slot),
        .ld_x    (in_data.point_x),
        .ld_y    (in_data.point_y),
        .coord   (coord_lut[in_data.cell_e]),
        .npts    (eff_count(count_e_reg)),
        .res     (sc_e)
    );

    stl_scan #(.MAX_POINTS(MAX_POINTS)) u_scan_p (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .tag     (in_tag),
        .ld_en   (is_load && in_data.curve_sel == stl_pkg::CURVE_PEAK),
        .ld_slot (in_data.point_slot),
        .ld_x    (in_data.point_x),
        .ld_y    (in_data.point_y),
        .coord   (coord_lut[in_data.cell_p]),
        .npts    (eff_count(count_p_reg)),
        .res     (sc_p)
    );

    // All three lanes carry the same item tag; the continentalness lane's copy is used.
    stl_interp u_interp_c (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .res   (sc_c),
        .tag   (it_c),
        .val   (v_c)
    );

    stl_interp u_interp_e (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .res   (sc_e),
        .tag   (),
        .val   (v_e)
    );

    stl_interp u_interp_p (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .res   (sc_p),
        .tag   (),
        .val   (v_p)
    );

    stl_blend u_blend (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .tag     (it_c),
        .cv      (v_c),
        .ev      (v_e),
        .pv      (v_p),
        .tag_out (blend_tag),
        .res     (out_data)
    );

endmodule

[hdl/stl_checker.sv]
// Port-level checks for the terrain height lookup, bound to the top level.
module stl_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input stl_pkg::stl_out_t out_data
);

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.refused |-> out_data.height_half == 14'd0)
        else $error("refused item carries a height");

    a_height_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.height_half <= 14'h3C00)
        else $error("height above one");

    // With no result waiting, the pipeline is free to take an item.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // While a result is being taken, an offered item is accepted too.
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && in_valid |-> in_ready)
        else $error("input blocked while output drains");

endmodule

bind spline_terrain_height_lut stl_checker u_stl_checker (.*);

[bench/spline_terrain_height_lut_test.sv]
// Self-checking testbench for the terrain height lookup: curve loads, evaluations and register phases.
module spline_terrain_height_lut_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS  = 8;
    localparam int CELLS = 32;
    localparam int DRAIN = 40;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    stl_pkg::stl_in_t               in_data = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    stl_pkg::stl_out_t              out_data;
    logic                           cfg_we = 1'b0;
    logic [stl_pkg::CFG_IDX_W-1:0]  cfg_idx = stl_pkg::REG_ENABLE;
    logic [stl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor copy of the curve tables and registers.
    logic [15:0] knot_x [3*NPTS];
    logic [15:0] knot_y [3*NPTS];
    logic        mode_on;
    logic [3:0]  knot_count [3];

    stl_pkg::stl_in_t  pending_items [$];
    stl_pkg::stl_out_t expected_heights [$];
    int sent_count = 0, taken_count = 0, result_count = 0, seen_results = 0;
    int mismatches = 0, eval_count = 0, load_count = 0, refusals = 0;
    int send_gap = 0, recv_wait = 0;
    bit quiet_sender = 1'b0, hold_output = 1'b0;

    spline_terrain_height_lut #(.MAX_POINTS(NPTS), .LUT_SIZE(CELLS)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint round_div(longint num, longint den);
        longint n2, d2, q;
        n2 = num * 2 + den;
        d2 = den * 2;
        q  = n2 / d2;
        if ((n2 % d2) != 0 && n2 < 0)
            q--;
        return q;
    endfunction

    function automatic int sx16(logic [15:0] v);
        return int'($signed(v));
    endfunction

    function automatic int cell_coord(logic [4:0] idx);
        int i;
        i = (idx > CELLS - 1) ? CELLS - 1 : int'(idx);
        return (i * 32768 + (CELLS - 1) / 2) / (CELLS - 1) - stl_pkg::ONE_Q;
    endfunction

    function automatic int curve_value(int curve, int x);
        int n, base, x0, x1, y0, y1;
        n    = (knot_count[curve] > NPTS) ? NPTS : int'(knot_count[curve]);
        base = curve * NPTS;
        if (n == 0)
            return 0;
        if (n == 1 || x <= sx16(knot_x[base]))
            return sx16(knot_y[base]);
        if (x >= sx16(knot_x[base+n-1]))
            return sx16(knot_y[base+n-1]);
        for (int i = 0; i + 1 < n; i++)
        begin
            x0 = sx16(knot_x[base+i]);
            x1 = sx16(knot_x[base+i+1]);
            if (x < x1)
            begin
                y0 = sx16(knot_y[base+i]);
                y1 = sx16(knot_y[base+i+1]);
                if (x1 - x0 <= 0)
                    return y0;
                return y0 + int'(round_div(longint'(x - x0) * longint'(y1 - y0),
                                           longint'(x1 - x0)));
            end
        end
        return sx16(knot_y[base+n-1]);
    endfunction

    function automatic logic [13:0] height_to_half(int v);
        int p, s, m, rem, mid, h;
        if (v == 0)
            return '0;
        p = 0;
        while (p < 14 && (v >> (p + 1)) != 0)
            p++;
        if (p <= 10)
            return 14'(((p + 1) << 10) + ((v << (10 - p)) & 'h3FF));
        s   = p - 10;
        m   = v >> s;
        rem = v & ((1 << s) - 1);
        mid = 1 << (s - 1);
        h   = ((p + 1) << 10) + (m - 1024);
        if (rem > mid || (rem == mid && (m & 1)))
            h++;
        return 14'(h);
    endfunction

    // Applies one item to the predictor state and, for an evaluation, queues the height it should give.
    task automatic predict_height(stl_pkg::stl_in_t it);
        longint c, e, p, num, h;
        stl_pkg::stl_out_t r;
        if (it.kind == stl_pkg::KIND_LOAD)
        begin
            load_count++;
            if (it.curve_sel != 2'd3)
            begin
                knot_x[it.curve_sel*NPTS+it.point_slot] = it.point_x;
                knot_y[it.curve_sel*NPTS+it.point_slot] = it.point_y;
            end
            return;
        end
        eval_count++;
        r = '0;
        if (!mode_on)
        begin
            r.refused = 1'b1;
            refusals++;
        end
        else
        begin
            c   = curve_value(0, cell_coord(it.cell_c));
            e   = curve_value(1, cell_coord(it.cell_e));
            p   = curve_value(2, cell_coord(it.cell_p));
            num = 3 * (2*c - stl_pkg::ONE_Q) * stl_pkg::ONE_Q
                + 2 * (2*p - stl_pkg::ONE_Q) * (stl_pkg::ONE_Q - e)
                + 5 * longint'(stl_pkg::ONE_Q) * stl_pkg::ONE_Q;
            h   = round_div(num, 10 * longint'(stl_pkg::ONE_Q));
            if (h < 0)
                h = 0;
            if (h > stl_pkg::ONE_Q)
                h = stl_pkg::ONE_Q;
            r.height_half = height_to_half(int'(h));
        end
        expected_heights = {expected_heights, r};
    endtask

    // Input side: accepted items go straight into the predictor.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            predict_height(in_data);
            taken_count <= taken_count + 1;
        end
    end

    always @(negedge clk)
    begin
        if (!(in_valid && sent_count != taken_count))
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (rst_n && pending_items.size() > 0)
            begin
                in_data    <= pending_items.pop_front();
                in_valid   <= 1'b1;
                sent_count <= sent_count + 1;
                send_gap   <= quiet_sender ? 0 : $urandom_range(0, 3);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output side: a fresh wait is drawn after every result taken.
    always @(negedge clk)
    begin
        int draw;
        draw = quiet_sender ? 0 : int'($urandom_range(0, 3));
        if (result_count != seen_results)
        begin
            seen_results <= result_count;
            if (draw > 0)
            begin
                recv_wait <= draw - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= rst_n && !hold_output;
        end
        else if (recv_wait > 0)
        begin
            recv_wait <= recv_wait - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n && !hold_output;
    end

    always @(posedge clk)
    begin
        stl_pkg::stl_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            result_count <= result_count + 1;
            if (expected_heights.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: height %h refused %b",
                             out_data.height_half, out_data.refused);
            end
            else
            begin
                want = expected_heights.pop_front();
                if (out_data.height_half !== want.height_half
                    || out_data.refused !== want.refused)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected height %h refused %b, got %h %b",
                                 want.height_half, want.refused,
                                 out_data.height_half, out_data.refused);
                end
            end
        end
    end

    // Long output stall once traffic is flowing, so the pipeline fills and backs up.
    initial
    begin
        wait (taken_count >= 400);
        @(negedge clk);
        hold_output = 1'b1;
        repeat (150) @(negedge clk);
        hold_output = 1'b0;
    end

    initial
    begin
        #3ms;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic write_reg(logic [stl_pkg::CFG_IDX_W-1:0] idx,
                             logic [stl_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        case (idx)
            stl_pkg::REG_ENABLE:  mode_on = val[0];
            stl_pkg::REG_COUNT_C: knot_count[0] = val;
            stl_pkg::REG_COUNT_E: knot_count[1] = val;
            default:              knot_count[2] = val;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_regs(logic en, logic [3:0] nc, logic [3:0] ne, logic [3:0] np);
        write_reg(stl_pkg::REG_ENABLE, stl_pkg::CFG_DATA_W'(en));
        write_reg(stl_pkg::REG_COUNT_C, nc);
        write_reg(stl_pkg::REG_COUNT_E, ne);
        write_reg(stl_pkg::REG_COUNT_P, np);
    endtask

    // Loads may still be in flight after the last result, hence the extra cycles.
    task automatic drain_block();
        while (pending_items.size() != 0 || sent_count != taken_count
               || expected_heights.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    function automatic stl_pkg::stl_in_t load_item(int sel, int slot, int x, int y);
        stl_pkg::stl_in_t it;
        it            = stl_pkg::stl_in_t'($urandom);
        it.kind       = stl_pkg::KIND_LOAD;
        it.curve_sel  = 2'(sel);
        it.point_slot = 3'(slot);
        it.point_x    = 16'(x);
        it.point_y    = 16'(y);
        return it;
    endfunction

    function automatic stl_pkg::stl_in_t eval_item(int c, int e, int p);
        stl_pkg::stl_in_t it;
        it        = stl_pkg::stl_in_t'({$urandom, $urandom});
        it.kind   = stl_pkg::KIND_EVAL;
        it.cell_c = 5'(c);
        it.cell_e = 5'(e);
        it.cell_p = 5'(p);
        return it;
    endfunction

    // A whole curve with ascending abscissae and random ordinates.
    task automatic queue_sorted_curve(int sel);
        int xs [$];
        for (int k = 0; k < NPTS; k++)
            xs = {xs, int'($urandom_range(0, 40000)) - 20000};
        xs.sort();
        for (int k = 0; k < NPTS; k++)
            pending_items = {pending_items,
                             load_item(sel, k, xs[k], int'($urandom_range(0, 65535)) - 32768)};
    endtask

    initial
    begin
        int cnt_pick [4];
        stl_pkg::stl_in_t it;
        mode_on = 1'b1;
        for (int i = 0; i < 3; i++)
            knot_count[i] = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        set_regs(1'b1, 4'd0, 4'd0, 4'd0);

        // Directed: every slot written, extremes of abscissa, an ignored curve select,
        // empty, single-point, full and oversized counts.
        for (int s = 0; s < 3; s++)
            for (int k = 0; k < NPTS; k++)
                pending_items = {pending_items,
                                 load_item(s, k, -16384 + k * 4681,
                                           (s == 1) ? k * 2340 : 16383 - k * 4000)};
        pending_items[0].point_x = 16'sh8000;
        pending_items[7].point_x = 16'sh7FFF;
        pending_items = {pending_items, load_item(3, 2, 0, 0)};
        pending_items = {pending_items, eval_item(0, 31, 31)};
        drain_block();
        set_regs(1'b1, 4'd8, 4'd8, 4'd8);
        pending_items = {pending_items, eval_item(0, 0, 0)};
        pending_items = {pending_items, eval_item(31, 31, 31)};
        pending_items = {pending_items, eval_item(16, 7, 24)};
        pending_items = {pending_items, load_item(2, 4, -4681, 100)};
        pending_items = {pending_items, eval_item(15, 16, 17)};
        drain_block();
        set_regs(1'b1, 4'd1, 4'd15, 4'd2);
        pending_items = {pending_items, eval_item(5, 0, 31)};
        pending_items = {pending_items, eval_item(31, 12, 3)};
        drain_block();
        write_reg(stl_pkg::REG_ENABLE, '0);
        pending_items = {pending_items, eval_item(31, 0, 9)};
        pending_items = {pending_items, load_item(1, 1, 3, -3)};
        drain_block();

        // Random phases: mostly sorted curve rewrites and evaluations, some noise loads.
        for (int ph = 0; ph < 12; ph++)
        begin
            quiet_sender = (ph % 4 == 3);
            for (int i = 0; i < 3; i++)
            begin
                case ($urandom_range(0, 4))
                    0: cnt_pick[i] = 0;
                    1: cnt_pick[i] = 1;
                    2: cnt_pick[i] = 8;
                    3: cnt_pick[i] = 15;
                    default: cnt_pick[i] = $urandom_range(2, 15);
                endcase
            end
            set_regs(ph != 5, 4'(cnt_pick[0]), 4'(cnt_pick[1]), 4'(cnt_pick[2]));
            while (pending_items.size() < 110)
            begin
                case ($urandom_range(0, 9))
                    0: queue_sorted_curve($urandom_range(0, 2));
                    1:
                    begin
                        it = stl_pkg::stl_in_t'({$urandom, $urandom});
                        it.kind = stl_pkg::KIND_LOAD;
                        pending_items = {pending_items, it};
                    end
                    default:
                        pending_items = {pending_items,
                                         eval_item($urandom_range(0, 31),
                                                   $urandom_range(0, 31),
                                                   $urandom_range(0, 31))};
                endcase
            end
            drain_block();
        end
        quiet_sender = 1'b0;

        $display("Covered %0d evaluations (%0d refused) and %0d breakpoint loads",
                 eval_count, refusals, load_count);
        $display("over 16 register settings, with a long output stall.");
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

[filelist.f]
hdl/stl_pkg.sv
hdl/stl_scan.sv
hdl/stl_interp.sv
hdl/stl_blend.sv
hdl/spline_terrain_height_lut.sv
hdl/stl_checker.sv
bench/spline_terrain_height_lut_test.sv
